/* rtl/nrc_pkg.sv */
// Shared types, constants and helpers for the nonce replay checker.
// No dependencies; imported by nrc_scan_ctrl, the top level and the checker.
`default_nettype none

package nrc_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int WORD_W    = 64;
  localparam int HITS_W    = 8;
  localparam int REMOVED_W = 7;
  localparam int STATUS_W  = 3;

  localparam logic [HITS_W-1:0]    HITS_MAX    = '1;
  localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;
  localparam logic [WORD_W-1:0]    WINDOW_RESET = WORD_W'(60000);

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT = 3'd0,
    ST_WINDOW = 3'd1,
    ST_REPLAY = 3'd2,
    ST_FULL   = 3'd3,
    ST_SWEEP  = 3'd4
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [WORD_W-1:0] now_ms;
    logic [WORD_W-1:0] key_seq;
    logic [WORD_W-1:0] key_time_ms;
    logic [WORD_W-1:0] key_random_lo;
    logic [WORD_W-1:0] key_random_hi;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_hi;
    logic [WORD_W-1:0] random_lo;
    logic [WORD_W-1:0] time_ms;
    logic [WORD_W-1:0] seq;
    logic [HITS_W-1:0] hits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t              status;
    logic [HITS_W-1:0]    seen_count;
    logic [REMOVED_W-1:0] removed_count;
  } res_t;

  function automatic logic outside_window(input logic [WORD_W-1:0] t,
                                          input logic [WORD_W-1:0] now,
                                          input logic [WORD_W-1:0] win);
    logic [WORD_W-1:0] d;
    d = (now > t) ? (now - t) : (t - now);
    return d > win;
  endfunction

endpackage

`default_nettype wire

/* rtl/nrc_entry_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
`default_nettype none

module nrc_entry_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/nrc_scan_ctrl.sv */
// Request sequencer: window test, table scan through the entry RAM, write-back.
// Depends on nrc_pkg; drives the read and write ports of nrc_entry_ram.
`default_nettype none

module nrc_scan_ctrl
  import nrc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire req_t               req_in,
  input  wire logic [WORD_W-1:0]  window,
  output logic                    ram_we,
  output logic      [IDX_W-1:0]   ram_waddr,
  output entry_t                  ram_wdata,
  output logic      [IDX_W-1:0]   ram_raddr,
  input  wire entry_t             ram_rdata,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output res_t                    res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FINISH = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t               state;
  req_t                 req;
  logic [IDX_W-1:0]     scan_idx;
  logic [ENTRIES-1:0]   slot_valid;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [HITS_W-1:0]    hit_hits;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [REMOVED_W-1:0] removed;

  logic                 cur_valid;
  logic                 key_match;
  logic                 cur_expired;
  logic                 req_outside;
  logic [HITS_W-1:0]    hits_new;
  res_t                 finish_res;

  assign cur_valid   = slot_valid[scan_idx];
  assign key_match   = (ram_rdata.random_hi == req.key_random_hi) &&
                       (ram_rdata.random_lo == req.key_random_lo) &&
                       (ram_rdata.time_ms   == req.key_time_ms) &&
                       (ram_rdata.seq       == req.key_seq);
  assign cur_expired = outside_window(ram_rdata.time_ms, req.now_ms, window);
  assign req_outside = outside_window(req.key_time_ms, req.now_ms, window);
  assign hits_new    = hit_found ? ((hit_hits == HITS_MAX) ? HITS_MAX : hit_hits + 1'b1)
                                 : HITS_W'(1);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  // Read one entry ahead of the one under test.
  assign ram_raddr = (state == S_START) ? '0 : scan_idx + 1'b1;

  assign ram_we    = (state == S_FINISH) && (req.req_type == REQ_CHECK) &&
                     (hit_found || free_found);
  assign ram_waddr = hit_found ? hit_idx : free_idx;
  assign ram_wdata = '{random_hi: req.key_random_hi, random_lo: req.key_random_lo,
                       time_ms: req.key_time_ms, seq: req.key_seq, hits: hits_new};

  always_comb begin
    finish_res = '{status: ST_FULL, seen_count: '0, removed_count: '0};
    if (req.req_type == REQ_SWEEP) begin
      finish_res = '{status: ST_SWEEP, seen_count: '0, removed_count: removed};
    end else if (hit_found) begin
      finish_res.status     = (hits_new > HITS_W'(1)) ? ST_REPLAY : ST_ACCEPT;
      finish_res.seen_count = hits_new;
    end else if (free_found) begin
      finish_res.status     = ST_ACCEPT;
      finish_res.seen_count = hits_new;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          if ((req.req_type == REQ_CHECK) && req_outside) begin
            state <= S_EMIT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if ((req.req_type == REQ_SWEEP) && cur_valid && cur_expired) begin
            slot_valid[scan_idx] <= 1'b0;
          end
          if (scan_idx == LAST_IDX) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (ram_we && !hit_found) begin
            slot_valid[free_idx] <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload and scan bookkeeping.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req <= req_in;
        end
      end
      S_START: begin
        scan_idx   <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        removed    <= '0;
        res        <= '{status: ST_WINDOW, seen_count: '0, removed_count: '0};
      end
      S_SCAN: begin
        if (req.req_type == REQ_SWEEP) begin
          if (cur_valid && cur_expired && (removed != REMOVED_MAX)) begin
            removed <= removed + 1'b1;
          end
        end else begin
          if (cur_valid && !hit_found && key_match) begin
            hit_found <= 1'b1;
            hit_idx   <= scan_idx;
            hit_hits  <= ram_rdata.hits;
          end
          if (!cur_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= scan_idx;
          end
        end
        scan_idx <= scan_idx + 1'b1;
      end
      S_FINISH: begin
        res <= finish_res;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nonce_replay_checker_unit.sv */
// Top level of the nonce replay checker: stream ports, window register, result register.
// Depends on nrc_pkg, nrc_entry_ram and nrc_scan_ctrl.
//
// One request at a time: a check looks a 256-bit nonce up in a 64-slot table held in a
// single-port-read synchronous RAM, a sweep drops every entry whose stored time lies
// outside the window around now_ms. The single read port sets the pace: every request
// that reaches the table scans all ENTRIES slots, one per cycle, and the next request is
// taken only after the result has gone to the result register; a check whose nonce falls
// outside the window returns without touching the table. Valid bits sit in flip-flops
// and clear at reset, so no clearing pass is needed. The result register decouples the
// output: a new request is taken while the previous result still waits for
// m_axis_tready. The window register may only be written while the block is idle.
`default_nettype none

module nonce_replay_checker_unit
  import nrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,         // time_window_ms
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // key_random_hi, key_random_lo, key_time_ms, key_seq, now_ms (64 bits each)
  input  wire logic [319:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,      // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status [2:0], seen_count [10:3], removed_count [17:11], zero fill above
  output logic [23:0]      m_axis_tdata
);

  logic [WORD_W-1:0] time_window_ms;
  req_t              req_in;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_res;

  // Window register: written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_window_ms <= WINDOW_RESET;
    end else if (cfg_we) begin
      time_window_ms <= cfg_wdata;
    end
  end

  // Unpack the request fields, lowest field first.
  assign req_in = '{req_type:      s_axis_tuser,
                    key_random_hi: s_axis_tdata[63:0],
                    key_random_lo: s_axis_tdata[127:64],
                    key_time_ms:   s_axis_tdata[191:128],
                    key_seq:       s_axis_tdata[255:192],
                    now_ms:        s_axis_tdata[319:256]};

  nrc_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_in    (req_in),
    .window    (time_window_ms),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The table: one RAM row per slot, the whole nonce and its hit count.
  // Writes happen only after a scan ends, before the next request's scan starts reading,
  // so no read that a scan uses ever meets a write to the same row.
  nrc_entry_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: load when empty or being drained, hold otherwise.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'b0, out_res.removed_count, out_res.seen_count, out_res.status};

endmodule

`default_nettype wire

/* rtl/nrc_checker.sv */
// Port-level assertions for nonce_replay_checker_unit, bound to the top level.
// Depends on nrc_pkg.
`default_nettype none

module nrc_checker
  import nrc_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [23:0]  m_axis_tdata
);

  logic [STATUS_W-1:0]  out_status;
  logic [HITS_W-1:0]    out_seen;
  logic [REMOVED_W-1:0] out_removed;

  assign out_status  = m_axis_tdata[2:0];
  assign out_seen    = m_axis_tdata[10:3];
  assign out_removed = m_axis_tdata[17:11];

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Hold off the next request while one is at work.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is at work");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // Accepted means first sighting; replay means a count above one.
  a_seen_consistent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((out_status != ST_ACCEPT) || (out_seen == HITS_W'(1))) &&
      ((out_status != ST_REPLAY) || (out_seen > HITS_W'(1))))
    else $error("hit count disagrees with status");

  // Only a sweep reports removals, and a sweep reports no hit count.
  a_sweep_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((out_status == ST_SWEEP) || (out_removed == '0)) &&
      ((out_status != ST_SWEEP) || (out_seen == '0)))
    else $error("sweep fields mixed with check fields");

endmodule

bind nonce_replay_checker_unit nrc_checker u_nrc_checker (.*);

`default_nettype wire
